// File: rtl/core/cq_pkg.sv
// ----------------------------------------------------------------------------
// cq_pkg
// Shared widths, register indexes and limits for the coefficient quantiser.
// ----------------------------------------------------------------------------
package cq_pkg;

  localparam int unsigned COEFF_W   = 16;
  localparam int unsigned LEVEL_W   = 16;
  localparam int unsigned SCALE_W   = 15;
  localparam int unsigned SHIFT_W   = 5;
  localparam int unsigned OFFSET_W  = 15;
  localparam int unsigned MAG_W     = 17;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 15;

  localparam int unsigned PROD_W    = 31;
  localparam int unsigned SUM_W     = 32;
  localparam int unsigned OFF_SH_W  = 26;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_SCALE  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SHIFT  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_OFFSET = 2'd2;

  localparam logic [SHIFT_W-1:0] SHIFT_LO = 5'd16;
  localparam logic [SHIFT_W-1:0] SHIFT_HI = 5'd27;

  localparam logic [SCALE_W-1:0]  SCALE_RST  = '0;
  localparam logic [OFFSET_W-1:0] OFFSET_RST = '0;

  localparam logic [SUM_W-1:0] POS_MAX = 32'd32767;
  localparam logic [SUM_W-1:0] NEG_MAG = 32'd32768;

endpackage

// File: rtl/core/cq_ifs.sv
// ----------------------------------------------------------------------------
// cq interfaces
// Valid/ready channels for coefficients, levels and register writes.
// ----------------------------------------------------------------------------
interface cq_coeff_if;
  logic                              valid;
  logic                              ready;
  logic signed [cq_pkg::COEFF_W-1:0] coeff;
  logic                              last_in;

  modport source (output valid, output coeff, output last_in, input ready);
  modport sink   (input valid, input coeff, input last_in, output ready);
endinterface

interface cq_level_if;
  logic                              valid;
  logic                              ready;
  logic signed [cq_pkg::LEVEL_W-1:0] level;
  logic                              last_out;
  logic                              block_nonzero;

  modport source (output valid, output level, output last_out, output block_nonzero,
                  input ready);
  modport sink   (input valid, input level, input last_out, input block_nonzero,
                  output ready);
endinterface

interface cq_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [cq_pkg::CFG_ADDR_W-1:0]    addr;
  logic [cq_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

// File: rtl/core/coefficient_quantizer.sv
// ----------------------------------------------------------------------------
// coefficient_quantizer
// Forward quantiser: level = sat16(sign * ((|coeff|*scale + off) >> shift)).
// ----------------------------------------------------------------------------
// in_ch  : one coefficient word per handshake, last_in marks end of block.
// out_ch : one level word per coefficient, in order, with last_out and a
//          running block_nonzero flag (includes the current level).
// cfg_ch : register writes (0 scale, 1 shift, 2 rounding offset), always
//          ready; unknown indexes are dropped. Write only while idle.
// Three register stages: input register, product register (17x15 multiply),
// result register (offset add, barrel shift, saturation). A word accepted from
// in_ch passes the input and product registers before it is presented on out_ch.
// Throughput is one word per cycle; the whole pipe advances together, set by
// the result register being empty or taken.
// When the receiver stalls with a level waiting, the whole pipe holds and
// in_ch.ready drops in the same cycle, bubbles included; up to three words
// sit in the stages until out_ch.ready returns.
// Reset clears stage valids and the nonzero flag and loads scale 0,
// shift 16, offset 0.
// ----------------------------------------------------------------------------
module coefficient_quantizer (
  input  logic       clk,
  input  logic       rst_n,
  cq_coeff_if.sink   in_ch,
  cq_level_if.source out_ch,
  cq_cfg_if.sink     cfg_ch
);

  // configuration
  logic [cq_pkg::SCALE_W-1:0]  scale_r;
  logic [cq_pkg::SHIFT_W-1:0]  shift_r;
  logic [cq_pkg::OFFSET_W-1:0] offset_r;

  // stage 0: input register
  logic                         s0_valid_r;
  logic                         s0_neg_r;
  logic                         s0_last_r;
  logic [cq_pkg::MAG_W-1:0]     s0_mag_r;

  // stage 1: product register
  logic                         s1_valid_r;
  logic                         s1_neg_r;
  logic                         s1_last_r;
  logic [cq_pkg::PROD_W-1:0]    s1_prod_r;

  // stage 2: result register
  logic                               out_valid_r;
  logic signed [cq_pkg::LEVEL_W-1:0]  level_r;
  logic                               last_r;
  logic                               nz_r;
  logic                               seen_r;

  logic                         advance;
  logic [cq_pkg::MAG_W-1:0]     mag_nxt;
  logic [cq_pkg::SHIFT_W-1:0]   sh_use;
  logic [cq_pkg::OFF_SH_W-1:0]  off_sh;
  logic [cq_pkg::SUM_W-1:0]     sum;
  logic [cq_pkg::SUM_W-1:0]     q;
  logic [cq_pkg::SUM_W-1:0]     q_sat;
  logic [cq_pkg::LEVEL_W-1:0]   level_nxt;
  logic                         nz_nxt;
  logic                         seen_nxt;

  assign advance      = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = advance;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.level         = level_r;
  assign out_ch.last_out      = last_r;
  assign out_ch.block_nonzero = nz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r  <= cq_pkg::SCALE_RST;
      shift_r  <= cq_pkg::SHIFT_LO;
      offset_r <= cq_pkg::OFFSET_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.addr)
        cq_pkg::REG_SCALE:  scale_r  <= cfg_ch.data[cq_pkg::SCALE_W-1:0];
        cq_pkg::REG_SHIFT:  shift_r  <= cfg_ch.data[cq_pkg::SHIFT_W-1:0];
        cq_pkg::REG_OFFSET: offset_r <= cfg_ch.data[cq_pkg::OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // magnitude of a 16-bit two's complement value, 0..32768
  always_comb begin
    if (in_ch.coeff[cq_pkg::COEFF_W-1]) begin
      mag_nxt = cq_pkg::MAG_W'(~{in_ch.coeff[cq_pkg::COEFF_W-1], in_ch.coeff})
                + cq_pkg::MAG_W'(1);
    end else begin
      mag_nxt = {1'b0, in_ch.coeff};
    end
  end

  // stage 2 arithmetic
  always_comb begin
    priority if (shift_r < cq_pkg::SHIFT_LO) begin
      sh_use = cq_pkg::SHIFT_LO;
    end else if (shift_r > cq_pkg::SHIFT_HI) begin
      sh_use = cq_pkg::SHIFT_HI;
    end else begin
      sh_use = shift_r;
    end
    off_sh = cq_pkg::OFF_SH_W'(offset_r) << (sh_use - cq_pkg::SHIFT_LO);
    sum    = {1'b0, s1_prod_r} + cq_pkg::SUM_W'(off_sh);
    q      = sum >> sh_use;
    if (s1_neg_r) begin
      q_sat     = (q > cq_pkg::NEG_MAG) ? cq_pkg::NEG_MAG : q;
      level_nxt = ~q_sat[cq_pkg::LEVEL_W-1:0] + cq_pkg::LEVEL_W'(1);
    end else begin
      q_sat     = (q > cq_pkg::POS_MAX) ? cq_pkg::POS_MAX : q;
      level_nxt = q_sat[cq_pkg::LEVEL_W-1:0];
    end
    nz_nxt   = seen_r || (level_nxt != '0);
    seen_nxt = s1_last_r ? 1'b0 : nz_nxt;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      seen_r      <= 1'b0;
    end else if (advance) begin
      s0_valid_r  <= in_ch.valid;
      s1_valid_r  <= s0_valid_r;
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        seen_r <= seen_nxt;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (advance) begin
      s0_neg_r  <= in_ch.coeff[cq_pkg::COEFF_W-1];
      s0_last_r <= in_ch.last_in;
      s0_mag_r  <= mag_nxt;
      s1_neg_r  <= s0_neg_r;
      s1_last_r <= s0_last_r;
      s1_prod_r <= cq_pkg::PROD_W'(s0_mag_r) * cq_pkg::PROD_W'(scale_r);
      level_r   <= level_nxt;
      last_r    <= s1_last_r;
      nz_r      <= nz_nxt;
    end
  end

  // flag is clear once the last word of a block has been formed
  a_seen_clear: assert property (@(posedge clk) disable iff (!rst_n)
    advance && s1_valid_r && s1_last_r |=> !seen_r)
    else $error("nonzero flag not cleared after end of block");

  // a nonzero level always reports a nonzero block
  a_nz_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (level_r != '0) |-> nz_r)
    else $error("nonzero level with block_nonzero low");

  // an accepted word enters the input register
  a_capture: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> s0_valid_r)
    else $error("accepted word lost at input register");

endmodule
